/* sv/mwf_pkg.sv */
`default_nettype none

package mwf_pkg;

  localparam int MWF_PIX_W      = 8;
  localparam int MWF_CFG_W      = 12;
  localparam int MWF_CFG_IDX_W  = 1;
  localparam int MWF_ROW_W      = 11;
  localparam int MWF_MAX_HEIGHT = 2048;

  localparam int MWF_WINDOW     = 3;
  localparam int MWF_MAX_WIDTH  = 2048;

  localparam int MWF_RESET_WIDTH  = 640;
  localparam int MWF_RESET_HEIGHT = 480;

  // configuration register indexes
  localparam logic [MWF_CFG_IDX_W-1:0] MWF_REG_FRAME_WIDTH  = 1'b0;
  localparam logic [MWF_CFG_IDX_W-1:0] MWF_REG_FRAME_HEIGHT = 1'b1;

  typedef logic [MWF_PIX_W-1:0] pix_t;

  // position flags carried with an item through the pipeline
  typedef struct packed {
    logic centred;
    logic med_en;
    logic last;
  } mwf_flags_t;

endpackage

`default_nettype wire

/* sv/mwf_ram.sv */
`default_nettype none

module mwf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/mwf_median.sv */
`default_nettype none

module mwf_median #(
  parameter int WINDOW = 3
) (
  input  wire logic [mwf_pkg::MWF_PIX_W-1:0] taps [WINDOW*WINDOW],
  output      logic [mwf_pkg::MWF_PIX_W-1:0] median
);
  import mwf_pkg::*;

  localparam int TAPS   = WINDOW * WINDOW;
  localparam int RANK_W = $clog2(TAPS);
  localparam logic [RANK_W-1:0] MID = RANK_W'(TAPS / 2);

  logic [RANK_W-1:0] rank [TAPS];

  // rank each tap: smaller values, plus equal values at lower index
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < TAPS; j++) begin
        if ((taps[j] < taps[i]) || ((j < i) && (taps[j] == taps[i]))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  // ranks form a permutation, so exactly one tap sits at the middle
  always_comb begin
    median = '0;
    for (int i = 0; i < TAPS; i++) begin
      if (rank[i] == MID) begin
        median = median | taps[i];
      end
    end
  end

endmodule

`default_nettype wire

/* sv/median_window_filter.sv */
`default_nettype none
// An accepted item is registered in stage 1 and moves into the output register
// when stage 1 advances; its result can be taken once out_stall is low.
// Throughput: one item per clock while not stalled by out_stall; line RAM is
// read at accept, written one stage later, bypassed when both hit one column.
// Reset: counters, valids and window clear, geometry returns to 640 x 480.
// The line RAM is not cleared; unwritten entries feed only zeroed border rows.

module median_window_filter #(
  parameter int WINDOW    = mwf_pkg::MWF_WINDOW,
  parameter int MAX_WIDTH = mwf_pkg::MWF_MAX_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [mwf_pkg::MWF_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mwf_pkg::MWF_CFG_W-1:0]     cfg_data,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [mwf_pkg::MWF_PIX_W-1:0]     pixel,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [mwf_pkg::MWF_PIX_W-1:0]     median_value,
  output      logic                              in_frame,
  output      logic                              frame_end
);
  import mwf_pkg::*;

  localparam int RAD    = WINDOW / 2;
  localparam int LINES  = WINDOW - 1;
  localparam int TAPS   = WINDOW * WINDOW;
  localparam int LINE_W = LINES * MWF_PIX_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int RESET_LAST_COL =
    (MWF_RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH - 1 : MWF_RESET_WIDTH - 1;
  localparam int RESET_LAST_ROW =
    (MWF_RESET_HEIGHT > MWF_MAX_HEIGHT) ? MWF_MAX_HEIGHT - 1 : MWF_RESET_HEIGHT - 1;

  // frame geometry, held as last index
  logic [COL_W-1:0]     last_col;
  logic [MWF_ROW_W-1:0] last_row;
  logic [COL_W-1:0]     last_col_next;
  logic [MWF_ROW_W-1:0] last_row_next;
  logic                 cfg_hit;

  logic [COL_W-1:0]     col;
  logic [MWF_ROW_W-1:0] row;

  logic                 s1_valid;
  pix_t                 s1_pixel;
  logic [COL_W-1:0]     s1_col;
  mwf_flags_t           s1_flags;
  logic                 s1_fwd;
  logic [LINE_W-1:0]    s1_fwd_data;
  logic                 s1_adv;

  logic                 in_acc;
  mwf_flags_t           flags_next;

  logic [LINE_W-1:0]    ram_rd_data;
  logic [LINE_W-1:0]    line_rd;
  logic [LINE_W-1:0]    line_wr;
  pix_t                 column [WINDOW];
  pix_t                 window [TAPS];
  pix_t                 window_next [TAPS];
  pix_t                 med_raw;

  // configuration decode with saturation to the legal geometry
  always_comb begin
    last_col_next = last_col;
    last_row_next = last_row;
    cfg_hit       = 1'b0;
    case (cfg_index)
      MWF_REG_FRAME_WIDTH: begin
        cfg_hit = 1'b1;
        if (cfg_data == '0) begin
          last_col_next = '0;
        end else if ({1'b0, cfg_data} > (MWF_CFG_W + 1)'(MAX_WIDTH)) begin
          last_col_next = COL_W'(MAX_WIDTH - 1);
        end else begin
          last_col_next = COL_W'(cfg_data - 1'b1);
        end
      end
      MWF_REG_FRAME_HEIGHT: begin
        cfg_hit = 1'b1;
        if (cfg_data == '0) begin
          last_row_next = '0;
        end else if ({1'b0, cfg_data} > (MWF_CFG_W + 1)'(MWF_MAX_HEIGHT)) begin
          last_row_next = MWF_ROW_W'(MWF_MAX_HEIGHT - 1);
        end else begin
          last_row_next = MWF_ROW_W'(cfg_data - 1'b1);
        end
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= COL_W'(RESET_LAST_COL);
      last_row <= MWF_ROW_W'(RESET_LAST_ROW);
    end else if (cfg_write) begin
      last_col <= last_col_next;
      last_row <= last_row_next;
    end
  end

  // handshake
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // raster counters; a config write starts a new frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_write && cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (in_acc) begin
      if (col == last_col) begin
        col <= '0;
        row <= (row == last_row) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_comb begin
    flags_next.centred = (row >= MWF_ROW_W'(RAD)) && (col >= COL_W'(RAD));
    flags_next.med_en  = (row >= MWF_ROW_W'(2 * RAD)) && (col >= COL_W'(2 * RAD));
    flags_next.last    = (col == last_col) && (row == last_row);
  end

  mwf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (line_wr),
    .rd_en   (in_acc),
    .rd_addr (col),
    .rd_data (ram_rd_data)
  );

  // stage 1: item with its column read from the line RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel    <= pixel;
      s1_col      <= col;
      s1_flags    <= flags_next;
      // same column written this edge: take the new line data directly
      s1_fwd      <= s1_adv && (s1_col == col);
      s1_fwd_data <= line_wr;
    end
  end

  assign line_rd = s1_fwd ? s1_fwd_data : ram_rd_data;

  always_comb begin
    column[WINDOW-1] = s1_pixel;
    for (int k = 0; k < LINES; k++) begin
      column[WINDOW-2-k] = line_rd[k*MWF_PIX_W +: MWF_PIX_W];
    end
    for (int k = 0; k < LINES; k++) begin
      line_wr[k*MWF_PIX_W +: MWF_PIX_W] = column[WINDOW-1-k];
    end
  end

  // shift the window left, new column enters at the right
  always_comb begin
    for (int r = 0; r < WINDOW; r++) begin
      for (int c = 0; c < WINDOW - 1; c++) begin
        window_next[r*WINDOW + c] = window[r*WINDOW + c + 1];
      end
      window_next[r*WINDOW + WINDOW - 1] = column[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        window[i] <= '0;
      end
    end else if (s1_adv) begin
      window <= window_next;
    end
  end

  mwf_median #(
    .WINDOW (WINDOW)
  ) u_median (
    .taps   (window_next),
    .median (med_raw)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      median_value <= s1_flags.med_en ? med_raw : '0;
      in_frame     <= s1_flags.centred;
      frame_end    <= s1_flags.last;
    end
  end

`ifndef SYNTH
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col <= last_col)
    else $error("column counter beyond frame width");

  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_frame) |-> (median_value == '0))
    else $error("nonzero median outside frame");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

/* test/tb_median_window_filter.sv */
`timescale 1ns / 100ps

module tb_median_window_filter;
  import mwf_pkg::*;

  localparam int RAD  = MWF_WINDOW / 2;
  localparam int TAPS = MWF_WINDOW * MWF_WINDOW;

  typedef struct {
    pix_t med;
    logic centred;
    logic last;
  } median_result_t;

  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_RAMP, PIX_NARROW} pix_style_t;

  class median_scoreboard;
    logic [MWF_CFG_W-1:0] width_reg;
    logic [MWF_CFG_W-1:0] height_reg;
    pix_t line_mem[MWF_WINDOW-1][MWF_MAX_WIDTH];
    pix_t win[TAPS];
    int col_pos;
    int row_pos;
    median_result_t pending[$];
    int errors;
    int pixels;
    int results;
    int frames;
    int medians;

    function new();
      width_reg  = MWF_CFG_W'(MWF_RESET_WIDTH);
      height_reg = MWF_CFG_W'(MWF_RESET_HEIGHT);
      foreach (line_mem[k, c]) line_mem[k][c] = '0;
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
      pixels  = 0;
      results = 0;
      frames  = 0;
      medians = 0;
    endfunction

    function void write_reg(logic [MWF_CFG_IDX_W-1:0] idx, logic [MWF_CFG_W-1:0] val);
      if (idx == MWF_REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
      col_pos = 0;
      row_pos = 0;
    endfunction

    function int span(logic [MWF_CFG_W-1:0] val, int top);
      if (val == 0) return 1;
      if (val > top) return top;
      return int'(val);
    endfunction

    function pix_t window_median();
      int lt;
      int le;
      pix_t m;
      m = '0;
      for (int a = 0; a < TAPS; a++) begin
        lt = 0;
        le = 0;
        for (int b = 0; b < TAPS; b++) begin
          if (win[b] < win[a]) lt++;
          if (win[b] <= win[a]) le++;
        end
        if (lt <= TAPS / 2 && le > TAPS / 2) m = win[a];
      end
      return m;
    endfunction

    function void note_pixel(pix_t p);
      int w;
      int h;
      int c;
      int r;
      pix_t column[MWF_WINDOW];
      median_result_t want;
      w = span(width_reg, MWF_MAX_WIDTH);
      h = span(height_reg, MWF_MAX_HEIGHT);
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      pixels++;

      // bottom of the column is the new pixel, line stores hold older rows
      column[MWF_WINDOW-1] = p;
      for (int k = 0; k < MWF_WINDOW - 1; k++)
        column[MWF_WINDOW-2-k] = line_mem[k][c];
      for (int k = 0; k < MWF_WINDOW - 1; k++)
        line_mem[k][c] = column[MWF_WINDOW-1-k];
      for (int y = 0; y < MWF_WINDOW; y++) begin
        for (int x = 0; x < MWF_WINDOW - 1; x++)
          win[y*MWF_WINDOW+x] = win[y*MWF_WINDOW+x+1];
        win[y*MWF_WINDOW+MWF_WINDOW-1] = column[y];
      end

      want.med     = (r >= 2*RAD && c >= 2*RAD) ? window_median() : '0;
      want.centred = (r >= RAD && c >= RAD);
      want.last    = (c == w - 1 && r == h - 1);
      pending.push_back(want);

      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void check_result(pix_t med, logic centred, logic last);
      median_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: median_value %0d in_frame %0b frame_end %0b",
                 $time, med, centred, last);
        errors++;
        return;
      end
      want = pending.pop_front();
      results++;
      if (last) frames++;
      if (med != 0) medians++;
      if (med !== want.med) begin
        $display("%0t: median_value expected %0d got %0d", $time, want.med, med);
        errors++;
      end
      if (centred !== want.centred) begin
        $display("%0t: in_frame expected %0b got %0b", $time, want.centred, centred);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: frame_end expected %0b got %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [MWF_CFG_IDX_W-1:0] cfg_index = MWF_REG_FRAME_WIDTH;
  logic [MWF_CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  pix_t pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pix_t median_value;
  logic in_frame;
  logic frame_end;

  median_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  median_window_filter DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .median_value(median_value),
    .in_frame(in_frame),
    .frame_end(frame_end)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_pixel(pixel);
      if (out_valid && !out_stall) sb.check_result(median_value, in_frame, frame_end);
    end
  end

  // receiver: switch between free flow, light, heavy and periodic stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left = stall_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_left % 8 < 3);
      endcase
    end
  end

  task automatic send_pixel(input pix_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic pix_t pick_pixel(pix_style_t style, int idx);
    case (style)
      PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PIX_RAMP:    return pix_t'(idx * 7);
      PIX_NARROW:  return pix_t'($urandom_range(120, 135));
      default:     return pix_t'($urandom);
    endcase
  endfunction

  task automatic feed(input int n, input pix_style_t style);
    for (int i = 0; i < n; i++) send_pixel(pick_pixel(style, i));
  endtask

  // hold the sender until every pending result is out, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [MWF_CFG_IDX_W-1:0] idx,
                           input logic [MWF_CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_write <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h);
    wait_idle();
    write_reg(MWF_REG_FRAME_WIDTH, MWF_CFG_W'(w));
    write_reg(MWF_REG_FRAME_HEIGHT, MWF_CFG_W'(h));
  endtask

  initial begin
    int w;
    int h;
    int n;
    int start_count;
    pix_style_t style;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: first row and the start of the second
    feed(MWF_RESET_WIDTH + 20, PIX_UNIFORM);

    // 3x3 frame, the smallest with a median: pixel extremes, one interior median
    set_frame(3, 3);
    send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h00);
    send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'hFF);
    send_pixel(8'h00); send_pixel(8'h00); send_pixel(8'hFF);

    // zero width and height saturate to a one-pixel frame
    set_frame(0, 0);
    send_pixel(8'hFF); send_pixel(8'h80); send_pixel(8'h01);

    // a register write in mid-frame restarts the frame
    set_frame(4, 3);
    feed(7, PIX_RAMP);
    wait_idle();
    write_reg(MWF_REG_FRAME_HEIGHT, 12'd3);
    feed(6, PIX_EXTREME);

    // random geometries, mostly whole frames
    start_count = sb.pixels;
    while (sb.pixels - start_count < 480) begin
      case ($urandom_range(0, 9))
        0, 1:    w = $urandom_range(0, 2);
        2:       w = $urandom_range(25, 40);
        default: w = $urandom_range(3, 16);
      endcase
      h = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      case ($urandom_range(0, 4))
        0: begin
          wait_idle();
          write_reg(MWF_REG_FRAME_WIDTH, MWF_CFG_W'(w));
          h = sb.span(sb.height_reg, MWF_MAX_HEIGHT);
        end
        1: begin
          wait_idle();
          write_reg(MWF_REG_FRAME_HEIGHT, MWF_CFG_W'(h));
          w = sb.span(sb.width_reg, MWF_MAX_WIDTH);
        end
        default: set_frame(w, h);
      endcase
      w = (w == 0) ? 1 : w;
      h = (h == 0) ? 1 : h;
      n = ($urandom_range(0, 3) != 0) ? w * h * $urandom_range(1, 2)
                                      : $urandom_range(1, w * h);
      style = pix_style_t'($urandom_range(0, 3));
      feed(n, style);
      if ($urandom_range(0, 5) == 0) wait_idle();
    end

    // out-of-range and maximum geometries: start of the first rows only
    set_frame(4095, 3);
    feed(50, PIX_UNIFORM);
    set_frame(3, 4095);
    feed(60, PIX_NARROW);
    set_frame(2048, 2048);
    feed(40, PIX_UNIFORM);
    set_frame(2049, 5);
    feed(40, PIX_EXTREME);

    wait_idle();
    repeat (10) @(posedge clk);

    $display("Run covered %0d pixels and %0d results over %0d complete frames,",
             sb.pixels, sb.results, sb.frames);
    $display("with %0d nonzero medians, geometries from 1x1 up to saturated 2048.",
             sb.medians);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timed out with %0d results pending", sb.pending.size());
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
sv/mwf_pkg.sv
sv/mwf_ram.sv
sv/mwf_median.sv
sv/median_window_filter.sv
test/tb_median_window_filter.sv
